/* rtl/core/vml_pkg.sv */
// Shared types and widths for the 2-D vector magnitude limiter.
// No dependencies; used by every module in rtl/core.
package vml_pkg;
	localparam int COMP_W = 16;
	localparam int LIM_W  = COMP_W - 1;
	localparam int MAG_W  = COMP_W;
	localparam int SQ_W   = 2 * COMP_W;
	localparam int WIDE_W = 64;
	localparam int QBITS  = COMP_W - 1;
	localparam int BIT_W  = 4;
	localparam logic ADDR_MAX_MAG = 1'b0;

	typedef struct packed {
		logic              vld;
		logic              lim_f;
		logic              nx;
		logic              ny;
		logic [COMP_W-1:0] in_x;
		logic [COMP_W-1:0] in_y;
		logic [SQ_W-1:0]   sq;
		logic [WIDE_W-1:0] ex;
		logic [WIDE_W-1:0] ey;
		logic [WIDE_W-1:0] px;
		logic [WIDE_W-1:0] py;
		logic [QBITS-1:0]  qx;
		logic [QBITS-1:0]  qy;
	} vml_item_t;
endpackage

/* rtl/core/vml_front.sv */
// Front stages: sign split, squares, squared length and target products.
// Depends on vml_pkg.
module vml_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [vml_pkg::COMP_W-1:0] in_x,
	input  logic [vml_pkg::COMP_W-1:0] in_y,
	input  logic [vml_pkg::LIM_W-1:0]  lim,
	output vml_pkg::vml_item_t         item
);
	import vml_pkg::*;

	logic              vld_s1, vld_s2, vld_s3;
	logic              nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic [COMP_W-1:0] rx_s1, ry_s1, rx_s2, ry_s2, rx_s3, ry_s3;
	logic [MAG_W-1:0]  ax_s1, ay_s1;
	logic [LIM_W-1:0]  lim_s1;
	logic [SQ_W-1:0]   axx_s2, ayy_s2, sq_s3;
	logic [2*LIM_W-1:0] lim2_s2;
	logic [WIDE_W-1:0] ex_s3, ey_s3;
	logic              limf_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1  <= in_x[COMP_W-1];
			ny_s1  <= in_y[COMP_W-1];
			ax_s1  <= in_x[COMP_W-1] ? (~in_x + 1'b1) : in_x;
			ay_s1  <= in_y[COMP_W-1] ? (~in_y + 1'b1) : in_y;
			rx_s1  <= in_x;
			ry_s1  <= in_y;
			lim_s1 <= lim;

			axx_s2  <= ax_s1 * ax_s1;
			ayy_s2  <= ay_s1 * ay_s1;
			lim2_s2 <= lim_s1 * lim_s1;
			nx_s2 <= nx_s1; ny_s2 <= ny_s1;
			rx_s2 <= rx_s1; ry_s2 <= ry_s1;

			sq_s3   <= axx_s2 + ayy_s2;
			limf_s3 <= (axx_s2 + ayy_s2) > SQ_W'(lim2_s2);
			ex_s3   <= WIDE_W'(axx_s2) * WIDE_W'(lim2_s2);
			ey_s3   <= WIDE_W'(ayy_s2) * WIDE_W'(lim2_s2);
			nx_s3 <= nx_s2; ny_s3 <= ny_s2;
			rx_s3 <= rx_s2; ry_s3 <= ry_s2;
		end
	end

	always_comb begin
		item       = '0;
		item.vld   = vld_s3;
		item.lim_f = limf_s3;
		item.nx    = nx_s3;
		item.ny    = ny_s3;
		item.in_x  = rx_s3;
		item.in_y  = ry_s3;
		item.sq    = sq_s3;
		item.ex    = ex_s3;
		item.ey    = ey_s3;
	end
endmodule

/* rtl/core/vml_step.sv */
// One restoring square-root-quotient bit for both components, registered.
// Depends on vml_pkg.
module vml_step (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [vml_pkg::BIT_W-1:0] bpos,
	input  vml_pkg::vml_item_t        d,
	output vml_pkg::vml_item_t        q
);
	import vml_pkg::*;

	logic [WIDE_W-1:0] sqw, base, cx, cy, addp;
	logic [QBITS-1:0]  bmask;
	vml_item_t         nxt;
	logic              vld_s1;
	vml_item_t         item_s1;

	always_comb begin
		sqw   = WIDE_W'(d.sq);
		base  = sqw << {bpos, 1'b0};
		addp  = sqw << bpos;
		bmask = QBITS'(1) << bpos;
		// (q + 2^b)^2 * sq - q^2 * sq = 2^(b+1)*q*sq + 2^(2b)*sq
		cx    = (d.px << (bpos + 1'b1)) + base;
		cy    = (d.py << (bpos + 1'b1)) + base;
		nxt   = d;
		if (cx <= d.ex) begin
			nxt.ex = d.ex - cx;
			nxt.px = d.px + addp;
			nxt.qx = d.qx | bmask;
		end
		if (cy <= d.ey) begin
			nxt.ey = d.ey - cy;
			nxt.py = d.py + addp;
			nxt.qy = d.qy | bmask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= d.vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= nxt;
	end

	always_comb begin
		q     = item_s1;
		q.vld = vld_s1;
	end
endmodule

/* rtl/core/vector_magnitude_limiter_2d_top.sv */
// Top level of the 2-D vector magnitude limiter: APB register, front stages,
// bit-step chain and output register. Depends on vml_pkg, vml_front, vml_step.
//
// Usage:
//  - s_axis carries one vector per word; m_axis returns one result per word,
//    in order. tuser on m_axis is was_limited.
//  - max_magnitude is written over APB at address 0 (reset value 256) and
//    should only change while no word is in flight.
//  - Pipeline: 19 register stages (three front stages, one stage per
//    quotient bit for 15 bits, one output register); the first stage
//    loads at the accept edge.
//  - Throughput: one word per cycle while m_axis is not stalled; the
//    15-stage bit chain is fully pipelined, one restoring step per stage.
//  - Reset clears every valid bit and sets the limit to 256.
//  - When m_axis_tready is low with a word waiting, the whole pipeline holds
//    and s_axis_tready drops; nothing is lost or repeated.
module vector_magnitude_limiter_2d_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [15:0] vec_x, [31:16] vec_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [15:0] out_x, [31:16] out_y
	output logic        m_axis_tuser,  // [0] was_limited
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vml_pkg::*;

	logic [LIM_W-1:0] max_mag_q;
	logic             en;
	vml_item_t        chain [0:QBITS];
	logic [COMP_W-1:0] ox, oy;
	vml_item_t        last;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MAX_MAG) ? 32'(max_mag_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_mag_q <= LIM_W'(256);
		else if (psel && penable && pwrite && pready && paddr == ADDR_MAX_MAG)
			max_mag_q <= pwdata[LIM_W-1:0];
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	vml_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (s_axis_tvalid && s_axis_tready),
		.in_x   (s_axis_tdata[COMP_W-1:0]),
		.in_y   (s_axis_tdata[2*COMP_W-1:COMP_W]),
		.lim    (max_mag_q),
		.item   (chain[0])
	);

	for (genvar g = 0; g < QBITS; g++) begin : g_step
		vml_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.bpos   (BIT_W'(QBITS - 1 - g)),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	assign last = chain[QBITS];

	always_comb begin
		ox = COMP_W'(last.qx);
		oy = COMP_W'(last.qy);
		if (last.nx) ox = ~ox + 1'b1;
		if (last.ny) oy = ~oy + 1'b1;
		if (!last.lim_f) begin
			ox = last.in_x;
			oy = last.in_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (en)
			m_axis_tvalid <= last.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {oy, ox};
			m_axis_tuser <= last.lim_f;
		end
	end

	// An empty output register never blocks the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// With a zero limit every limited vector collapses to the origin.
	a_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser && max_mag_q == '0) |-> (m_axis_tdata == 32'd0))
		else $error("zero limit produced a nonzero vector");

	// A held output word stays put while stalled.
	a_hold_pipeline: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output word changed during stall");
endmodule

/* tb/vector_magnitude_limiter_2d_top_tb.sv */
// Testbench for vector_magnitude_limiter_2d_top: drives vectors over the input
// stream and limits over APB, predicts each result exactly. Also uses vml_pkg.
`timescale 1ns / 1ps

class limiter_scoreboard;
	typedef struct packed {
		logic [15:0] ox;
		logic [15:0] oy;
		logic        lim;
	} vec_result_t;

	vec_result_t pending[$];
	logic [14:0] limit;
	int          mismatches;
	int          checked;
	int          limited_seen;

	function new();
		limit = 15'd256;
		mismatches = 0;
		checked = 0;
		limited_seen = 0;
	endfunction

	// Largest q with q*q*sq <= (c*lim)^2, found one bit at a time.
	function logic [15:0] scale_mag(logic [63:0] c, logic [63:0] lim, logic [63:0] sq);
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [63:0]  q;
		logic [63:0]  t;
		rhs = 128'(c * c) * 128'(lim * lim);
		q = 0;
		for (int b = 14; b >= 0; b--) begin
			t = q | (64'd1 << b);
			lhs = 128'(t * t) * 128'(sq);
			if (lhs <= rhs)
				q = t;
		end
		return q[15:0];
	endfunction

	function void note_vector(logic [15:0] vx, logic [15:0] vy);
		vec_result_t r;
		logic        nx;
		logic        ny;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] sq;
		logic [15:0] mx;
		logic [15:0] my;
		nx = vx[15];
		ny = vy[15];
		ax = nx ? 64'(17'h10000 - vx) : 64'(vx);
		ay = ny ? 64'(17'h10000 - vy) : 64'(vy);
		sq = ax * ax + ay * ay;
		if (sq > 64'(limit) * 64'(limit)) begin
			mx = scale_mag(ax, 64'(limit), sq);
			my = scale_mag(ay, 64'(limit), sq);
			r.ox = nx ? -mx : mx;
			r.oy = ny ? -my : my;
			r.lim = 1'b1;
		end else begin
			r.ox = vx;
			r.oy = vy;
			r.lim = 1'b0;
		end
		pending.push_back(r);
	endfunction

	function void check_result(logic [15:0] ox, logic [15:0] oy, logic lim);
		vec_result_t e;
		checked++;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: x=%h y=%h lim=%b", ox, oy, lim);
			return;
		end
		e = pending.pop_front();
		if (lim)
			limited_seen++;
		if (e.ox !== ox || e.oy !== oy || e.lim !== lim) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected x=%h y=%h lim=%b, got x=%h y=%h lim=%b",
					e.ox, e.oy, e.lim, ox, oy, lim);
		end
	endfunction
endclass

module vector_magnitude_limiter_2d_top_tb;
	import vml_pkg::*;

	localparam int LATENCY = 19;
	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [15:0] vec_x, [31:16] vec_y
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [15:0] out_x, [31:16] out_y
	logic        m_axis_tuser;   // [0] was_limited
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic        paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	limiter_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  stall_cycles;
	int  sent;
	int  limits_used;

	vector_magnitude_limiter_2d_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random backpressure, check every accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: count cycles with no accepted word on either side.
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Leave tvalid high after the accept; callers that pause drop it.
	task automatic send_vector(logic [15:0] vx, logic [15:0] vy);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {vy, vx};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_vector(vx, vy);
		sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_limit(logic [14:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_MAG;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.limit = value;
		limits_used++;
	endtask

	// Mostly vectors near the limit circle, the rest anywhere.
	task automatic random_vectors(int count);
		logic [15:0] vx;
		logic [15:0] vy;
		int          r;
		for (int i = 0; i < count; i++) begin
			r = 2 * int'(sb.limit) + 2;
			if ($urandom_range(3) != 0 && r < 32768) begin
				vx = 16'($urandom_range(2 * r) - r);
				vy = 16'($urandom_range(2 * r) - r);
			end else begin
				vx = 16'($urandom);
				vy = 16'($urandom);
			end
			send_vector(vx, vy);
		end
	endtask

	task automatic directed_vectors();
		send_vector(16'h0000, 16'h0000);
		send_vector(16'h8000, 16'h8000);
		send_vector(16'h7fff, 16'h7fff);
		send_vector(16'h8000, 16'h7fff);
		send_vector(16'h0100, 16'h0000);
		send_vector(16'h0000, 16'hff00);
		send_vector(16'h0099, 16'h00cc);
		send_vector(16'hff67, 16'h0034);
		send_vector(16'h0101, 16'h0000);
		send_vector(16'h0001, 16'h0001);
		send_vector(16'hffff, 16'h8000);
		send_vector(16'h5555, 16'haaaa);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 1'b0;
		pwdata = '0;
		sent = 0;
		limits_used = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limit of 1.0 first, including the exact-length cases.
		directed_vectors();
		write_limit(15'd0);
		directed_vectors();
		write_limit(15'h7fff);
		directed_vectors();

		send_idle_pct = 28;
		recv_idle_pct = 52;
		write_limit(15'd300);
		random_vectors(150);
		write_limit(15'd1);
		random_vectors(100);

		send_idle_pct = 52;
		recv_idle_pct = 28;
		write_limit(15'h5a5a);
		random_vectors(120);
		// Hold the sender until the pipeline is empty, then resume.
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		random_vectors(30);
		write_limit(15'h2a5);
		random_vectors(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(15'h7fff);
		random_vectors(100);
		write_limit(15'd0);
		random_vectors(50);
		write_limit(15'($urandom_range(1, 32766)));
		random_vectors(114);

		drain();
		$display("Sent %0d vectors over %0d limit settings; %0d results checked, %0d limited.",
			sent, limits_used + 1, sb.checked, sb.limited_seen);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d bad words, %0d still expected", sb.mismatches, sb.pending.size());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* vector_magnitude_limiter_2d_top.f */
rtl/core/vml_pkg.sv
rtl/core/vml_front.sv
rtl/core/vml_step.sv
rtl/core/vector_magnitude_limiter_2d_top.sv
tb/vector_magnitude_limiter_2d_top_tb.sv
